// ===== rtl/topk_pkg.sv =====
package topk_pkg;

    // default sizes
    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_WIDTH_DEF = 16;

    // fixed field widths
    localparam int OP_W    = 2;
    localparam int TAG_W   = 16;
    localparam int IDX_W   = 4;
    localparam int TOTAL_W = 5;

    typedef logic [OP_W-1:0] t_op;

    // operation codes
    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_READ   = 2'd1;
    localparam t_op OP_CLEAR  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic do_cmp;
        logic do_upd;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_stall;
    } t_dp_sts;

endpackage

// ===== rtl/topk_ifs.sv =====
// input item channel
interface topk_in_if #(
    parameter int KEY_W = topk_pkg::KEY_WIDTH_DEF
);
    logic                       valid;
    logic                       ready;
    logic [topk_pkg::OP_W-1:0]  op;
    logic [KEY_W-1:0]           new_key;
    logic [topk_pkg::TAG_W-1:0] new_tag;
    logic [topk_pkg::IDX_W-1:0] read_index;

    modport source (output valid, op, new_key, new_tag, read_index, input ready);
    modport sink   (input valid, op, new_key, new_tag, read_index, output ready);
endinterface

// result channel
interface topk_out_if #(
    parameter int KEY_W = topk_pkg::KEY_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         accepted;
    logic [topk_pkg::IDX_W-1:0]   insert_position;
    logic [topk_pkg::TOTAL_W-1:0] entry_total;
    logic                         read_valid;
    logic [KEY_W-1:0]             read_key;
    logic [topk_pkg::TAG_W-1:0]   read_tag;

    modport source (output valid, accepted, insert_position, entry_total, read_valid,
                    read_key, read_tag, input ready);
    modport sink   (input valid, accepted, insert_position, entry_total, read_valid,
                    read_key, read_tag, output ready);
endinterface

// configuration write channel
interface topk_cfg_if;
    logic valid;
    logic ready;
    logic keep_largest;

    modport source (output valid, keep_largest, input ready);
    modport sink   (input valid, keep_largest, output ready);
endinterface

// ===== rtl/topk_ctrl.sv =====
module topk_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  topk_pkg::t_dp_sts i_sts,
    output topk_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (!i_sts.out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands
    assign o_in_ready     = (r_state == S_IDLE);
    assign o_cmd.load_in  = i_in_valid && (r_state == S_IDLE);
    assign o_cmd.do_cmp   = (r_state == S_CMP);
    assign o_cmd.do_upd   = (r_state == S_UPD) && !i_sts.out_stall;

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load_in, o_cmd.do_cmp, o_cmd.do_upd}))
        else $error("more than one datapath command at once");

    a_load_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_in |=> (r_state == S_CMP))
        else $error("compare did not follow an accepted transaction");

    a_upd_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.do_upd |=> o_in_ready)
        else $error("not ready after update");

endmodule

// ===== rtl/topk_dp.sv =====
module topk_dp #(
    parameter int CAPACITY  = topk_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = topk_pkg::KEY_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  topk_pkg::t_dp_cmd            i_cmd,
    output topk_pkg::t_dp_sts            o_sts,
    input  topk_pkg::t_op                i_op,
    input  logic [KEY_WIDTH-1:0]         i_new_key,
    input  logic [topk_pkg::TAG_W-1:0]   i_new_tag,
    input  logic [topk_pkg::IDX_W-1:0]   i_read_index,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_keep_largest,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_accepted,
    output logic [topk_pkg::IDX_W-1:0]   o_insert_position,
    output logic [topk_pkg::TOTAL_W-1:0] o_entry_total,
    output logic                         o_read_valid,
    output logic [KEY_WIDTH-1:0]         o_read_key,
    output logic [topk_pkg::TAG_W-1:0]   o_read_tag
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int XW  = (CW > topk_pkg::TOTAL_W) ? CW : topk_pkg::TOTAL_W;

    // a ranks strictly ahead of b
    function automatic logic ranks_ahead(input logic [KEY_WIDTH-1:0] a,
                                         input logic [KEY_WIDTH-1:0] b,
                                         input logic                 keep);
        return keep ? (a > b) : (a < b);
    endfunction

    logic                       r_keep;
    topk_pkg::t_op              r_op;
    logic [KEY_WIDTH-1:0]       r_key;
    logic [topk_pkg::TAG_W-1:0] r_tag;
    logic [topk_pkg::IDX_W-1:0] r_ridx;
    logic [KEY_WIDTH-1:0]       r_keys [CAPACITY];
    logic [topk_pkg::TAG_W-1:0] r_tags [CAPACITY];
    logic [CW-1:0]              r_count;
    logic [CAPACITY-1:0]        r_match;
    logic                       r_reject;
    logic [IW-1:0]              r_limit;
    logic                       r_out_valid;

    logic                w_full;
    logic [IW-1:0]       w_limit;
    logic [CAPACITY-1:0] w_match;
    logic                w_reject;
    logic [IW-1:0]       w_pos;
    logic [XW-1:0]       w_pos_x;
    logic                w_ins;
    logic [CW-1:0]       w_cnt_next;
    logic [XW-1:0]       w_cnt_x;
    logic [XW-1:0]       w_ridx_x;
    logic [IW-1:0]       w_ridx;
    logic                w_rd_ok;

    // ranking register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= 1'b1;
        end else if (i_cfg_valid) begin
            r_keep <= i_cfg_keep_largest;
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= i_op;
            r_key  <= i_new_key;
            r_tag  <= i_new_tag;
            r_ridx <= i_read_index;
        end
    end

    // compare the new key against every stored entry
    assign w_full  = (r_count == CW'(CAPACITY));
    assign w_limit = w_full ? IW'(CAPACITY - 1) : r_count[IW-1:0];

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_match[i] = (IW'(i) < w_limit) && !ranks_ahead(r_key, r_keys[i], r_keep);
        end
    end

    assign w_reject = w_full && ranks_ahead(r_keys[CAPACITY-1], r_key, r_keep);

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_cmp) begin
            r_match  <= w_match;
            r_reject <= w_reject;
            r_limit  <= w_limit;
        end
    end

    // landing position: just past the last entry that ranks equal or ahead
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (r_match[i]) begin
                w_pos = IW'(i + 1);
            end
        end
    end

    assign w_ins = (r_op == topk_pkg::OP_INSERT) && !r_reject;

    // entry row: write at the landing position, shift the tail down by one
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (i_cmd.do_upd && w_ins && (w_pos == '0)) begin
                    r_keys[g] <= r_key;
                    r_tags[g] <= r_tag;
                end
            end
        end else begin : g_body
            always_ff @(posedge i_clk) begin
                if (i_cmd.do_upd && w_ins) begin
                    if (IW'(g) == w_pos) begin
                        r_keys[g] <= r_key;
                        r_tags[g] <= r_tag;
                    end else if ((IW'(g) > w_pos) && (IW'(g) <= r_limit)) begin
                        r_keys[g] <= r_keys[g-1];
                        r_tags[g] <= r_tags[g-1];
                    end
                end
            end
        end
    end

    // entry count
    always_comb begin
        w_cnt_next = r_count;
        if (r_op == topk_pkg::OP_CLEAR) begin
            w_cnt_next = '0;
        end else if (w_ins && !w_full) begin
            w_cnt_next = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.do_upd) begin
            r_count <= w_cnt_next;
        end
    end

    // read lookup
    assign w_ridx_x = XW'(r_ridx);
    assign w_ridx   = w_ridx_x[IW-1:0];
    assign w_rd_ok  = (r_op == topk_pkg::OP_READ) && (w_ridx_x < XW'(r_count))
                      && (w_ridx_x < XW'(CAPACITY));
    assign w_pos_x  = XW'(w_pos);
    assign w_cnt_x  = XW'(w_cnt_next);

    // result register
    assign o_sts.out_stall = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.do_upd) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_upd) begin
            o_accepted        <= w_ins;
            o_insert_position <= w_ins ? w_pos_x[topk_pkg::IDX_W-1:0] : '0;
            o_entry_total     <= w_cnt_x[topk_pkg::TOTAL_W-1:0];
            o_read_valid      <= w_rd_ok;
            o_read_key        <= w_rd_ok ? r_keys[w_ridx] : '0;
            o_read_tag        <= w_rd_ok ? r_tags[w_ridx] : '0;
        end
    end

    assign o_out_valid = r_out_valid;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.do_upd && (r_op == topk_pkg::OP_CLEAR)) |=> (r_count == '0))
        else $error("clear left entries");

    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.do_upd && (r_op == topk_pkg::OP_INSERT) && r_reject) |=> $stable(r_count))
        else $error("rejected insert changed the count");

endmodule

// ===== rtl/bounded_sorted_insert_topk.sv =====
// Top-k list: keeps up to CAPACITY key/tag entries sorted best first, where best
// means largest key when keep_largest is set (reset value) and smallest otherwise.
// An insert lands just after every entry ranking equal or ahead; on a full list it
// drops the last entry or is rejected if it ranks behind it. Reads return the entry
// at an index (zero fields and read_valid low past the count); clear empties the
// list. Each input transaction gives exactly one result transaction. An item is
// captured at acceptance, then compared in parallel against all entries, and then
// the priority encode and shift of the entry row load the result register. A new
// item is accepted only once the previous one has left the update step. The
// result register lets the next item be accepted while a result still waits, and
// a stalled output holds the update step. Write keep_largest only while the block
// is idle.
module bounded_sorted_insert_topk #(
    parameter int CAPACITY  = topk_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = topk_pkg::KEY_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    topk_in_if.sink           i_in,
    topk_out_if.source        o_out,
    topk_cfg_if.sink          i_cfg
);

    topk_pkg::t_dp_cmd w_cmd;
    topk_pkg::t_dp_sts w_sts;
    logic              w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    topk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    topk_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_op               (i_in.op),
        .i_new_key          (i_in.new_key),
        .i_new_tag          (i_in.new_tag),
        .i_read_index       (i_in.read_index),
        .i_cfg_valid        (i_cfg.valid),
        .i_cfg_keep_largest (i_cfg.keep_largest),
        .o_out_valid        (o_out.valid),
        .i_out_ready        (o_out.ready),
        .o_accepted         (o_out.accepted),
        .o_insert_position  (o_out.insert_position),
        .o_entry_total      (o_out.entry_total),
        .o_read_valid       (o_out.read_valid),
        .o_read_key         (o_out.read_key),
        .o_read_tag         (o_out.read_tag)
    );

endmodule
